[rtl/core/bmprd_pkg.sv]
package bmprd_pkg;

    // Pixel format codes
    localparam logic [2:0] FMT_PAL4   = 3'd0;
    localparam logic [2:0] FMT_PAL8   = 3'd1;
    localparam logic [2:0] FMT_RGB565 = 3'd2;
    localparam logic [2:0] FMT_BGR    = 3'd3;
    localparam logic [2:0] FMT_BGRA   = 3'd4;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_ROWS   = 2'd2;
    localparam logic [1:0] CFG_FLIP_ROWS    = 2'd3;

    localparam int CFG_W = 13;

    // Request kinds carried in s_tuser
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    // One decoded pixel waiting in the result stage
    typedef struct packed {
        logic        use_pal;
        logic        pal_ok;
        logic [23:0] rgb;
        logic [7:0]  alpha;
        logic [11:0] col;
        logic        last;
    } slot_t;

    // 5-bit channel to 8 bits as x*255/31, truncated: 8x plus floor(7x/31)
    function automatic logic [7:0] exp5(input logic [4:0] x);
        logic [2:0] f;
        f = 3'(x >= 5'd5) + 3'(x >= 5'd9) + 3'(x >= 5'd14) + 3'(x >= 5'd18)
          + 3'(x >= 5'd23) + 3'(x >= 5'd27) + 3'(x >= 5'd31);
        return {x, 3'b000} + {5'd0, f};
    endfunction

    // 6-bit channel to 8 bits as x*255/63, truncated: 4x plus floor(x/21)
    function automatic logic [7:0] exp6(input logic [5:0] x);
        logic [1:0] f;
        f = 2'(x >= 6'd21) + 2'(x >= 6'd42) + 2'(x == 6'd63);
        return {x, 2'b00} + {6'd0, f};
    endfunction

    // Padding bytes after a row, from the low bits of the width
    function automatic logic [1:0] row_pad(input logic [2:0] fmt, input logic [2:0] w3);
        logic [3:0] half;
        logic [1:0] rb;
        half = ({1'b0, w3} + 4'd1) >> 1;
        case (fmt)
            FMT_PAL4:   rb = half[1:0];
            FMT_PAL8:   rb = w3[1:0];
            FMT_RGB565: rb = {w3[0], 1'b0};
            FMT_BGR:    rb = 2'd0 - w3[1:0];
            default:    rb = 2'd0;
        endcase
        return 2'd0 - rb;
    endfunction

endpackage

[rtl/core/bmp_pixel_row_decoder.sv]
// Channel  | Dir | Handshake          | Payload (lowest bits first)
// s_       | in  | s_tvalid/s_tready  | tdata: data_byte, palette_index, red, green, blue;
//          |     |                    | tuser: req_type
// m_       | out | m_tvalid/m_tready  | tdata: red, green, blue, alpha, dest_row, dest_column;
//          |     |                    | tlast: last_pixel
// cfg_     | in  | cfg_we             | cfg_addr: register index, cfg_wdata: value
//
// One input word is taken per cycle while s_tready is high; it passes the input stage and
// then the result stage. At 4 bpp each byte gives two pixels, so the single output port
// sets the pace. The palette is a 256x24 memory with one write and two read ports.
// Reset (synchronous) initialises control and counters, not data registers or the palette.
// A stalled m_ side holds the result stage, then the input stage, then s_tready drops.
module bmp_pixel_row_decoder #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_ROWS      = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, palette_index, red, green, blue
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red, green, blue, alpha, dest_row, dest_column
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int XW  = (WW > bmprd_pkg::CFG_W) ? WW : bmprd_pkg::CFG_W;
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int XR  = (RW > bmprd_pkg::CFG_W) ? RW : bmprd_pkg::CFG_W;
    localparam int PAW = $clog2(PALETTE_DEPTH);

    // Configuration registers
    logic [2:0]  pixel_format_reg;
    logic [12:0] image_width_reg;
    logic [12:0] image_rows_reg;
    logic        flip_rows_reg;

    // Input stage
    logic        a_valid_reg;
    logic        a_type_reg;
    logic [7:0]  a_byte_reg;

    // Position state
    logic [RW-1:0] src_row_reg, src_row_next;
    logic [WW-1:0] col_cnt_reg, col_cnt_next;
    logic [1:0]    phase_reg, phase_next;
    logic [1:0]    pad_left_reg, pad_left_next;
    logic [23:0]   held_reg, held_next;

    // Result stage
    logic                 b_valid_reg;
    logic                 b_two_reg;
    logic                 b_sel_reg;
    bmprd_pkg::slot_t     slot0_reg, slot1_reg, slot0_next, slot1_next;
    logic [11:0]          b_row_reg, b_row_next;
    logic                 emit0, emit1;

    // Palette memory and its read data
    logic [23:0]    pal_mem [PALETTE_DEPTH];
    logic [23:0]    rd0_reg, rd1_reg;
    logic [PAW-1:0] raddr0, raddr1;

    logic           s_acc, a_adv, b_last, b_free;
    logic [WW-1:0]  w;
    logic [RW-1:0]  rows;

    // Effective sizes, saturated at the maxima
    always_comb begin
        if (XW'(image_width_reg) > XW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(image_width_reg);
        end
        if (XR'(image_rows_reg) > XR'(MAX_ROWS)) begin
            rows = RW'(MAX_ROWS);
        end else begin
            rows = RW'(image_rows_reg);
        end
    end

    // Handshake
    assign b_last   = !b_two_reg || b_sel_reg;
    assign b_free   = !b_valid_reg || (m_tready && b_last);
    assign a_adv    = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || b_free;
    assign s_acc    = s_tvalid && s_tready;

    // Decode one word against the position state
    always_comb begin
        logic [RW-1:0] sr;
        logic [RW:0]   nr;
        logic [WW-1:0] col, col1, col_after;
        logic [1:0]    need, pad;
        logic          done, do_next;
        logic [RW-1:0] nr_from;
        logic [4:0]    r5, b5;
        logic [5:0]    g6;

        src_row_next  = src_row_reg;
        col_cnt_next  = col_cnt_reg;
        phase_next    = phase_reg;
        pad_left_next = pad_left_reg;
        held_next     = held_reg;
        emit0         = 1'b0;
        emit1         = 1'b0;
        slot0_next    = '0;
        slot1_next    = '0;
        nr            = '0;
        sr            = (src_row_reg >= rows) ? rows - 1'b1 : src_row_reg;
        col           = (col_cnt_reg >= w) ? w - 1'b1 : col_cnt_reg;
        col1          = col + 1'b1;
        col_after     = col1;
        need          = (pixel_format_reg == bmprd_pkg::FMT_BGR) ? 2'd2 : 2'd3;
        pad           = bmprd_pkg::row_pad(pixel_format_reg, 3'(w));
        done          = 1'b0;
        do_next       = 1'b0;
        nr_from       = src_row_reg;
        r5            = a_byte_reg[7:3];
        g6            = {a_byte_reg[2:0], held_reg[7:5]};
        b5            = held_reg[4:0];
        b_row_next    = flip_rows_reg ? 12'(rows - 1'b1 - sr) : 12'(sr);
        raddr0        = (pixel_format_reg == bmprd_pkg::FMT_PAL4) ?
                        PAW'(a_byte_reg[7:4]) : PAW'(a_byte_reg);
        raddr1        = PAW'(a_byte_reg[3:0]);

        slot0_next.col  = 12'(col);
        slot0_next.last = (sr == rows - 1'b1) && (col == w - 1'b1);
        slot1_next.col  = 12'(col1);
        slot1_next.last = (sr == rows - 1'b1) && (col1 == w - 1'b1);

        if (a_type_reg == bmprd_pkg::REQ_PIXEL && pixel_format_reg <= bmprd_pkg::FMT_BGRA
            && w != '0 && rows != '0) begin
            if (pad_left_reg != 2'd0) begin
                // Skip a padding byte
                pad_left_next = pad_left_reg - 1'b1;
                do_next       = (pad_left_reg == 2'd1);
            end else begin
                src_row_next = sr;
                col_cnt_next = col;
                nr_from      = sr;
                case (pixel_format_reg)
                    bmprd_pkg::FMT_PAL4: begin
                        emit0              = 1'b1;
                        slot0_next.use_pal = 1'b1;
                        slot0_next.pal_ok  = 1'b1;
                        if (col1 < w) begin
                            emit1              = 1'b1;
                            slot1_next.use_pal = 1'b1;
                            slot1_next.pal_ok  = 1'b1;
                            col_after          = col1 + 1'b1;
                        end
                        done = 1'b1;
                    end
                    bmprd_pkg::FMT_PAL8: begin
                        emit0              = 1'b1;
                        slot0_next.use_pal = 1'b1;
                        slot0_next.pal_ok  = {1'b0, a_byte_reg} < 9'(PALETTE_DEPTH);
                        done               = 1'b1;
                    end
                    bmprd_pkg::FMT_RGB565: begin
                        if (phase_reg == 2'd0) begin
                            held_next  = {16'd0, a_byte_reg};
                            phase_next = 2'd1;
                        end else begin
                            emit0          = 1'b1;
                            slot0_next.rgb = {bmprd_pkg::exp5(r5), bmprd_pkg::exp6(g6),
                                              bmprd_pkg::exp5(b5)};
                            done           = 1'b1;
                        end
                    end
                    default: begin
                        if (phase_reg < need) begin
                            // Hold the byte at its place in the pixel
                            case (phase_reg)
                                2'd0:    held_next[7:0]   = a_byte_reg;
                                2'd1:    held_next[15:8]  = a_byte_reg;
                                default: held_next[23:16] = a_byte_reg;
                            endcase
                            phase_next = phase_reg + 1'b1;
                        end else begin
                            emit0 = 1'b1;
                            if (pixel_format_reg == bmprd_pkg::FMT_BGR) begin
                                slot0_next.rgb = {a_byte_reg, held_reg[15:0]};
                            end else begin
                                slot0_next.rgb   = held_reg;
                                slot0_next.alpha = a_byte_reg;
                            end
                            done = 1'b1;
                        end
                    end
                endcase
                // Close the pixel and, at the row end, start padding or the next row
                if (done) begin
                    phase_next   = 2'd0;
                    held_next    = '0;
                    col_cnt_next = col_after;
                    if (col_after >= w) begin
                        if (pad == 2'd0) begin
                            do_next = 1'b1;
                        end else begin
                            pad_left_next = pad;
                        end
                    end
                end
            end
            if (do_next) begin
                nr            = {1'b0, nr_from} + 1'b1;
                col_cnt_next  = '0;
                phase_next    = 2'd0;
                pad_left_next = 2'd0;
                held_next     = '0;
                src_row_next  = (nr >= {1'b0, rows}) ? '0 : nr[RW-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= bmprd_pkg::FMT_BGRA;
            image_width_reg  <= 13'd1;
            image_rows_reg   <= 13'd0;
            flip_rows_reg    <= 1'b0;
            a_valid_reg      <= 1'b0;
            src_row_reg      <= '0;
            col_cnt_reg      <= '0;
            phase_reg        <= 2'd0;
            pad_left_reg     <= 2'd0;
            held_reg         <= '0;
            b_valid_reg      <= 1'b0;
            b_two_reg        <= 1'b0;
            b_sel_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    bmprd_pkg::CFG_PIXEL_FORMAT: pixel_format_reg <= cfg_wdata[2:0];
                    bmprd_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                    bmprd_pkg::CFG_IMAGE_ROWS:   image_rows_reg   <= cfg_wdata;
                    bmprd_pkg::CFG_FLIP_ROWS:    flip_rows_reg    <= cfg_wdata[0];
                    default:                     flip_rows_reg    <= flip_rows_reg;
                endcase
            end
            // Input stage occupancy
            if (s_acc) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            // Advance position state and load the result stage
            if (a_adv) begin
                src_row_reg  <= src_row_next;
                col_cnt_reg  <= col_cnt_next;
                phase_reg    <= phase_next;
                pad_left_reg <= pad_left_next;
                held_reg     <= held_next;
                b_valid_reg  <= emit0;
                b_two_reg    <= emit1;
                b_sel_reg    <= 1'b0;
            end else if (b_valid_reg && m_tready) begin
                if (b_last) begin
                    b_valid_reg <= 1'b0;
                end else begin
                    b_sel_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_type_reg <= s_tuser;
            a_byte_reg <= s_tdata[7:0];
        end
        if (a_adv) begin
            slot0_reg <= slot0_next;
            slot1_reg <= slot1_next;
            b_row_reg <= b_row_next;
        end
    end

    // Palette: write on acceptance, read both ports as the word leaves the input stage
    always_ff @(posedge aclk) begin
        if (s_acc && s_tuser == bmprd_pkg::REQ_PALETTE
            && {1'b0, s_tdata[15:8]} < 9'(PALETTE_DEPTH)) begin
            // Store red in the high byte, blue in the low byte
            pal_mem[PAW'(s_tdata[15:8])] <= {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
        end
        if (a_adv) begin
            rd0_reg <= pal_mem[raddr0];
            rd1_reg <= pal_mem[raddr1];
        end
    end

    // Drive the current result word
    always_comb begin
        bmprd_pkg::slot_t cur;
        logic [23:0]      rd;
        logic [23:0]      rgb;
        cur = b_sel_reg ? slot1_reg : slot0_reg;
        rd  = b_sel_reg ? rd1_reg : rd0_reg;
        if (cur.use_pal) begin
            rgb = cur.pal_ok ? rd : 24'd0;
        end else begin
            rgb = cur.rgb;
        end
        m_tvalid = b_valid_reg;
        m_tdata  = {cur.col, b_row_reg, cur.alpha, rgb[7:0], rgb[15:8], rgb[23:16]};
        m_tlast  = cur.last;
    end

endmodule
